// ===== hw/rtl/refcount_threshold_cache_policy_macros.svh =====
// assertion helpers for the checker of the cache policy block
`ifndef REFCOUNT_THRESHOLD_CACHE_POLICY_MACROS_SVH
`define REFCOUNT_THRESHOLD_CACHE_POLICY_MACROS_SVH

// same-cycle implication
`define RTCP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache policy check failed");

// next-cycle implication
`define RTCP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache policy check failed");

`endif

// ===== hw/rtl/rtcp_pkg.sv =====
`timescale 1ns / 1ps
package rtcp_pkg;

   localparam int SLOT_DEPTH       = 256;
   localparam int SLOT_W           = 8;
   localparam int SLOTN_W          = 9;
   localparam int ID_W             = 8;
   localparam int THR_W            = 16;
   localparam int CNT_OUT_W        = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int DEF_NUM_CONTENTS = 256;
   localparam int DEF_COUNT_WIDTH  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd4;

   localparam logic [1:0] ACT_INTEREST  = 2'd0;
   localparam logic [1:0] ACT_DECREMENT = 2'd1;

   typedef enum logic [2:0] {
      CH_IDLE,
      CH_ROTATE,
      CH_WRITE,
      CH_PUNCH,
      CH_SHIFT
   } chain_op_type;

   typedef struct packed {
      chain_op_type      op;
      logic [SLOT_W-1:0] idx;
      logic [ID_W-1:0]   wid;
   } chain_cmd_type;

endpackage

// ===== hw/rtl/rtcp_cell.sv =====
`timescale 1ns / 1ps
module rtcp_cell #(
   parameter int POS  = 0,
   parameter bit LAST = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rtcp_pkg::chain_cmd_type   cmd,
   input  logic [rtcp_pkg::ID_W-1:0] right_id,
   input  logic                      right_vld,
   input  logic                      left_hole,
   output logic [rtcp_pkg::ID_W-1:0] id,
   output logic                      vld,
   output logic                      hole
);
   import rtcp_pkg::*;

   localparam logic [SLOT_W-1:0] POS_IDX = SLOT_W'(POS);

   logic [ID_W-1:0] id_ff, id_in;
   logic            vld_ff, vld_in;
   logic            hole_ff, hole_in;

   always_comb begin
      id_in   = id_ff;
      vld_in  = vld_ff;
      hole_in = hole_ff;
      unique case (cmd.op)
         CH_ROTATE: begin
            id_in   = right_id;
            vld_in  = right_vld;
            hole_in = 1'b0;
         end
         CH_WRITE: begin
            if (cmd.idx == POS_IDX) begin
               id_in  = cmd.wid;
               vld_in = 1'b1;
            end
         end
         CH_PUNCH: begin
            hole_in = vld_ff && (id_ff == cmd.wid);
         end
         CH_SHIFT: begin
            // the hole walks up; the tail entry becomes empty
            if (hole_ff) begin
               if (!LAST && right_vld) begin
                  id_in = right_id;
               end else begin
                  vld_in = 1'b0;
               end
               hole_in = 1'b0;
            end else begin
               hole_in = left_hole && vld_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         hole_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         hole_ff <= hole_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id   = id_ff;
   assign vld  = vld_ff;
   assign hole = hole_ff;

endmodule

// ===== hw/rtl/rtcp_slot_chain.sv =====
`timescale 1ns / 1ps
module rtcp_slot_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  rtcp_pkg::chain_cmd_type   cmd,
   output logic [rtcp_pkg::ID_W-1:0] head_id
);
   import rtcp_pkg::*;

   logic [ID_W-1:0] id_w [SLOT_DEPTH];
   logic            vld_w [SLOT_DEPTH];
   logic            hole_w [SLOT_DEPTH];

   // ring wiring: each cell sees the next one, the last sees the head
   for (genvar g = 0; g < SLOT_DEPTH; g++) begin : g_cell
      logic left_hole;
      if (g == 0) begin : g_first
         assign left_hole = 1'b0;
      end else begin : g_rest
         assign left_hole = hole_w[g-1];
      end
      rtcp_cell #(
         .POS  (g),
         .LAST (g == SLOT_DEPTH - 1)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .right_id  (id_w[(g + 1) % SLOT_DEPTH]),
         .right_vld (vld_w[(g + 1) % SLOT_DEPTH]),
         .left_hole (left_hole),
         .id        (id_w[g]),
         .vld       (vld_w[g]),
         .hole      (hole_w[g])
      );
   end

   assign head_id = id_w[0];

endmodule

// ===== hw/rtl/refcount_threshold_cache_policy.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | action, content_id, random_slot
// rsp      | out       | rsp_valid/rsp_stall  | hit, count, admitted, removed,
//          |           |                      | removed_id, occupancy
// csr      | in        | csr_write            | csr_index, csr_wdata
//
// lookups, plain counts and admissions into a free slot go from EVAL straight to DONE
// an eviction feeds a full rotation of the slot ring into the count memory
// read port to find the victim
// a removal lets a hole walk up the 256-cell slot row
// after reset a clearing pass over all NUM_CONTENTS count entries holds off requests
// a result waits in the rsp register while the next transaction is taken
module refcount_threshold_cache_policy #(
   parameter int NUM_CONTENTS = rtcp_pkg::DEF_NUM_CONTENTS,
   parameter int COUNT_WIDTH  = rtcp_pkg::DEF_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_action,
   input  logic [rtcp_pkg::ID_W-1:0]       req_content_id,
   input  logic [rtcp_pkg::SLOT_W-1:0]     req_random_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_hit,
   output logic [rtcp_pkg::CNT_OUT_W-1:0]  rsp_count,
   output logic                            rsp_admitted,
   output logic                            rsp_removed,
   output logic [rtcp_pkg::ID_W-1:0]       rsp_removed_id,
   output logic [rtcp_pkg::SLOTN_W-1:0]    rsp_occupancy,
   input  logic                            csr_write,
   input  logic [rtcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rtcp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtcp_pkg::*;

   localparam int CIDW = (NUM_CONTENTS > 1) ? $clog2(NUM_CONTENTS) : 1;
   localparam int CW   = COUNT_WIDTH;
   localparam logic [CIDW-1:0]    CLR_LAST  = CIDW'(NUM_CONTENTS - 1);
   localparam logic [SLOTN_W-1:0] DEPTH_N   = SLOTN_W'(SLOT_DEPTH);
   localparam logic [SLOTN_W-1:0] SCAN_LAST = SLOTN_W'(SLOT_DEPTH - 1);

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b00000001,
      S_IDLE    = 8'b00000010,
      S_EVAL    = 8'b00000100,
      S_SCAN    = 8'b00001000,
      S_FLUSH   = 8'b00010000,
      S_REPLACE = 8'b00100000,
      S_SHIFT   = 8'b01000000,
      S_DONE    = 8'b10000000
   } state_type;

   function automatic logic [CIDW-1:0] to_addr(input logic [ID_W-1:0] v);
      logic [CIDW+ID_W-1:0] e;
      e = {{CIDW{1'b0}}, v};
      return e[CIDW-1:0];
   endfunction

   function automatic logic [CNT_OUT_W-1:0] to_out(input logic [CW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[CNT_OUT_W-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [THR_W-1:0]   upper_ff, lower_ff;
   logic [SLOTN_W-1:0] cap_ff;
   logic               limit_ff, mode_ff;

   logic [SLOTN_W-1:0] used_ff, used_in;
   logic [CIDW-1:0]    clr_ff, clr_in;
   logic [SLOTN_W-1:0] sc_ff, sc_in;

   logic [1:0]         act_ff, act_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [SLOT_W-1:0]  rnd_ff, rnd_in;

   logic               cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]  cmp_pos_ff, cmp_pos_in;
   logic [ID_W-1:0]    cmp_id_ff, cmp_id_in;
   logic               found_ff, found_in;
   logic [CW-1:0]      best_cnt_ff, best_cnt_in;
   logic [SLOT_W-1:0]  best_idx_ff, best_idx_in;
   logic [ID_W-1:0]    best_id_ff, best_id_in;
   logic [SLOT_W-1:0]  vs_ff, vs_in;
   logic [SLOTN_W-1:0] lim_ff, lim_in;

   logic               res_hit_ff, res_hit_in;
   logic [CW-1:0]      res_cnt_ff, res_cnt_in;
   logic               res_adm_ff, res_adm_in;
   logic               res_rem_ff, res_rem_in;
   logic [ID_W-1:0]    res_rid_ff, res_rid_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                 rsp_adm_ff, rsp_adm_in;
   logic                 rsp_rem_ff, rsp_rem_in;
   logic [ID_W-1:0]      rsp_rid_ff, rsp_rid_in;
   logic [SLOTN_W-1:0]   rsp_occ_ff, rsp_occ_in;

   // count and in-cache stores
   logic [CW-1:0] cnt_mem [NUM_CONTENTS];
   logic          inc_mem [NUM_CONTENTS];
   logic [CW-1:0] cnt_rd_ff;
   logic          inc_rd_ff;
   logic          cnt_we, inc_we, inc_wdata;
   logic [CIDW-1:0] cnt_waddr, inc_waddr, rd_addr;
   logic [CW-1:0]   cnt_wdata;

   chain_cmd_type   cmd;
   logic [ID_W-1:0] head_id;

   logic               accept, id_ok, admit, dec_rm, full, take, rsp_free;
   logic [CW-1:0]      cnt_inc, cnt_dec;
   logic [SLOTN_W-1:0] cap_eff, lim_calc, lim_m1;

   rtcp_slot_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .head_id (head_id)
   );

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign id_ok    = (32'(id_ff) < 32'(NUM_CONTENTS));

   assign cnt_inc = (cnt_rd_ff == {CW{1'b1}}) ? cnt_rd_ff : cnt_rd_ff + CW'(1);
   assign cnt_dec = cnt_rd_ff - CW'(1);
   assign admit   = (32'(cnt_rd_ff) >= 32'(upper_ff)) && !inc_rd_ff;
   assign dec_rm  = (cnt_rd_ff != '0) && (32'(cnt_dec) < 32'(lower_ff)) && inc_rd_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = SLOTN_W'(1);
      end else if (cap_ff > DEPTH_N) begin
         cap_eff = DEPTH_N;
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign full     = (used_ff >= DEPTH_N) || (limit_ff && (used_ff >= cap_eff));
   assign lim_calc = limit_ff ? cap_eff : DEPTH_N;
   assign lim_m1   = lim_calc - SLOTN_W'(1);

   // victim candidate test on the delayed head of the ring
   assign take = mode_ff
      ? ((SLOTN_W'(cmp_pos_ff) < lim_ff) && (!found_ff || (cnt_rd_ff < best_cnt_ff)))
      : (cmp_pos_ff == vs_ff);

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      clr_in      = clr_ff;
      sc_in       = sc_ff;
      act_in      = act_ff;
      id_in       = id_ff;
      rnd_in      = rnd_ff;
      cmp_vld_in  = 1'b0;
      cmp_pos_in  = cmp_pos_ff;
      cmp_id_in   = cmp_id_ff;
      found_in    = found_ff;
      best_cnt_in = best_cnt_ff;
      best_idx_in = best_idx_ff;
      best_id_in  = best_id_ff;
      vs_in       = vs_ff;
      lim_in      = lim_ff;
      res_hit_in  = res_hit_ff;
      res_cnt_in  = res_cnt_ff;
      res_adm_in  = res_adm_ff;
      res_rem_in  = res_rem_ff;
      res_rid_in  = res_rid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      rsp_adm_in   = rsp_adm_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_rid_in   = rsp_rid_ff;
      rsp_occ_in   = rsp_occ_ff;
      cnt_we     = 1'b0;
      cnt_waddr  = to_addr(id_ff);
      cnt_wdata  = cnt_inc;
      inc_we     = 1'b0;
      inc_waddr  = to_addr(id_ff);
      inc_wdata  = 1'b0;
      rd_addr    = to_addr(id_ff);
      cmd        = '{op: CH_IDLE, idx: '0, wid: '0};

      if (cmp_vld_ff && take) begin
         found_in    = 1'b1;
         best_cnt_in = cnt_rd_ff;
         best_idx_in = cmp_pos_ff;
         best_id_in  = cmp_id_ff;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = '0;
            inc_we    = 1'b1;
            inc_waddr = clr_ff;
            inc_wdata = 1'b0;
            clr_in    = clr_ff + CIDW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = to_addr(req_content_id);
            if (accept) begin
               act_in   = req_action;
               id_in    = req_content_id;
               rnd_in   = req_random_slot;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_hit_in = 1'b0;
            res_cnt_in = '0;
            res_adm_in = 1'b0;
            res_rem_in = 1'b0;
            res_rid_in = '0;
            state_in   = S_DONE;
            if (id_ok) begin
               res_hit_in = inc_rd_ff;
               res_cnt_in = cnt_rd_ff;
               if (act_ff == ACT_INTEREST) begin
                  cnt_we     = 1'b1;
                  cnt_wdata  = cnt_inc;
                  res_cnt_in = cnt_inc;
                  if (admit) begin
                     inc_we     = 1'b1;
                     inc_wdata  = 1'b1;
                     res_hit_in = 1'b1;
                     res_adm_in = 1'b1;
                     if (!full) begin
                        cmd     = '{op: CH_WRITE, idx: used_ff[SLOT_W-1:0], wid: id_ff};
                        used_in = used_ff + SLOTN_W'(1);
                     end else begin
                        res_rem_in = 1'b1;
                        lim_in     = lim_calc;
                        vs_in      = ({1'b0, rnd_ff} < lim_calc) ? rnd_ff
                                                                 : lim_m1[SLOT_W-1:0];
                        found_in   = 1'b0;
                        sc_in      = '0;
                        state_in   = S_SCAN;
                     end
                  end
               end else if (act_ff == ACT_DECREMENT) begin
                  if (cnt_rd_ff != '0) begin
                     cnt_we     = 1'b1;
                     cnt_wdata  = cnt_dec;
                     res_cnt_in = cnt_dec;
                     if (dec_rm) begin
                        inc_we     = 1'b1;
                        inc_wdata  = 1'b0;
                        cmd        = '{op: CH_PUNCH, idx: '0, wid: id_ff};
                        used_in    = used_ff - SLOTN_W'(1);
                        res_hit_in = 1'b0;
                        res_rem_in = 1'b1;
                        res_rid_in = id_ff;
                        sc_in      = '0;
                        state_in   = S_SHIFT;
                     end
                  end
               end
            end
         end
         S_SCAN: begin
            cmd        = '{op: CH_ROTATE, idx: '0, wid: '0};
            rd_addr    = to_addr(head_id);
            cmp_vld_in = 1'b1;
            cmp_pos_in = sc_ff[SLOT_W-1:0];
            cmp_id_in  = head_id;
            sc_in      = sc_ff + SLOTN_W'(1);
            if (sc_ff == SCAN_LAST) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_REPLACE;
         end
         S_REPLACE: begin
            cmd        = '{op: CH_WRITE, idx: best_idx_ff, wid: id_ff};
            inc_we     = 1'b1;
            inc_waddr  = to_addr(best_id_ff);
            inc_wdata  = 1'b0;
            res_rid_in = best_id_ff;
            state_in   = S_DONE;
         end
         S_SHIFT: begin
            cmd   = '{op: CH_SHIFT, idx: '0, wid: '0};
            sc_in = sc_ff + SLOTN_W'(1);
            if (sc_ff == SCAN_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_count_in = to_out(res_cnt_ff);
               rsp_adm_in   = res_adm_ff;
               rsp_rem_in   = res_rem_ff;
               rsp_rid_in   = res_rid_ff;
               rsp_occ_in   = used_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (inc_we) begin
         inc_mem[inc_waddr] <= inc_wdata;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
      inc_rd_ff <= inc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         used_ff      <= '0;
         clr_ff       <= '0;
         sc_ff        <= '0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= THR_W'(3);
         lower_ff     <= THR_W'(1);
         cap_ff       <= SLOTN_W'(16);
         limit_ff     <= 1'b1;
         mode_ff      <= 1'b1;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         clr_ff       <= clr_in;
         sc_ff        <= sc_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_UPPER: upper_ff <= csr_wdata;
               CSR_LOWER: lower_ff <= csr_wdata;
               CSR_CAP:   cap_ff   <= csr_wdata[SLOTN_W-1:0];
               CSR_LIMIT: limit_ff <= csr_wdata[0];
               CSR_MODE:  mode_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      id_ff        <= id_in;
      rnd_ff       <= rnd_in;
      cmp_pos_ff   <= cmp_pos_in;
      cmp_id_ff    <= cmp_id_in;
      best_cnt_ff  <= best_cnt_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      vs_ff        <= vs_in;
      lim_ff       <= lim_in;
      res_hit_ff   <= res_hit_in;
      res_cnt_ff   <= res_cnt_in;
      res_adm_ff   <= res_adm_in;
      res_rem_ff   <= res_rem_in;
      res_rid_ff   <= res_rid_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
      rsp_adm_ff   <= rsp_adm_in;
      rsp_rem_ff   <= rsp_rem_in;
      rsp_rid_ff   <= rsp_rid_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_admitted   = rsp_adm_ff;
   assign rsp_removed    = rsp_rem_ff;
   assign rsp_removed_id = rsp_rid_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

// ===== hw/rtl/rtcp_checker.sv =====
`timescale 1ns / 1ps
`include "refcount_threshold_cache_policy_macros.svh"
module rtcp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [1:0]                      req_action,
   input logic [rtcp_pkg::ID_W-1:0]       req_content_id,
   input logic [rtcp_pkg::SLOT_W-1:0]     req_random_slot,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_hit,
   input logic [rtcp_pkg::CNT_OUT_W-1:0]  rsp_count,
   input logic                            rsp_admitted,
   input logic                            rsp_removed,
   input logic [rtcp_pkg::ID_W-1:0]       rsp_removed_id,
   input logic [rtcp_pkg::SLOTN_W-1:0]    rsp_occupancy,
   input logic                            csr_write,
   input logic [rtcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [rtcp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtcp_pkg::*;

   // a stalled result holds
   `RTCP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_count) && $stable(rsp_removed_id) && $stable(rsp_occupancy))
   // an admitting response also reports a hit
   `RTCP_ASSERT_IMP(a_adm_hit, clock, reset, rsp_valid && rsp_admitted, rsp_hit)
   // no departure, no departing id
   `RTCP_ASSERT_IMP(a_rid_zero, clock, reset, rsp_valid && !rsp_removed, rsp_removed_id == '0)
   // one transaction at a time
   `RTCP_ASSERT_NXT(a_busy, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind refcount_threshold_cache_policy rtcp_checker u_rtcp_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import rtcp_pkg::*;

   localparam logic [1:0] ACT_LOOKUP = 2'd2;
   localparam logic [1:0] ACT_SPARE  = 2'd3;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         N_PHASE    = 8;
   localparam int         PER_PHASE  = 190;

   typedef struct packed {
      logic                 hit;
      logic [CNT_OUT_W-1:0] count;
      logic                 admitted;
      logic                 removed;
      logic [ID_W-1:0]      removed_id;
      logic [SLOTN_W-1:0]   occupancy;
   } cache_rsp_t;

   typedef struct {
      logic [1:0]      act;
      logic [ID_W-1:0] id;
      logic [7:0]      rnd;
      bit              typed;
      cache_rsp_t      want;
   } stim_row_t;

   typedef struct {
      int unsigned upper;
      int unsigned lower;
      int unsigned cap;
      int unsigned limit;
      int unsigned mode;
      int unsigned pool;
      bit          calm;
   } policy_cfg_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_action;
   logic [ID_W-1:0]       req_content_id;
   logic [SLOT_W-1:0]     req_random_slot;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_hit;
   logic [CNT_OUT_W-1:0]  rsp_count;
   logic                  rsp_admitted;
   logic                  rsp_removed;
   logic [ID_W-1:0]       rsp_removed_id;
   logic [SLOTN_W-1:0]    rsp_occupancy;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   refcount_threshold_cache_policy dut (.*);

   // predictor state
   logic [15:0] pcount [256];
   bit          pcached [256];
   int unsigned pslot_of [256];
   int unsigned pslots [256];
   int unsigned pused;
   int unsigned cfg_upper, cfg_lower, cfg_cap, cfg_limit, cfg_mode;

   cache_rsp_t  pending_rsp [$];
   stim_row_t   directed [$];
   policy_cfg_t phases [N_PHASE];
   bit          calm;
   int          errors = 0;
   int          n_results = 0;
   int          n_items, n_evict, n_remove, n_admit;
   int          idle_cycles, stall_left;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic cache_rsp_t predict_policy(logic [1:0] act, logic [ID_W-1:0] id,
                                                 logic [7:0] rnd);
      cache_rsp_t r;
      int unsigned capv, lim, vs, victim, s, bestc;
      bit full;
      r = '0;
      if (act == ACT_INTEREST) begin
         if (pcount[id] >= cfg_upper && !pcached[id]) begin
            capv = (cfg_cap == 0) ? 1 : ((cfg_cap > 256) ? 256 : cfg_cap);
            full = (pused >= 256) || (cfg_limit != 0 && pused >= capv);
            if (!full) begin
               pslots[pused] = id;
               pslot_of[id] = pused;
               pused++;
            end else begin
               lim = (cfg_limit != 0) ? capv : 256;
               if (cfg_mode == 0) begin
                  vs = (rnd < lim) ? rnd : lim - 1;
               end else begin
                  vs = 0;
                  bestc = pcount[pslots[0]];
                  for (int i = 1; i < lim; i++) begin
                     if (pcount[pslots[i]] < bestc) begin
                        bestc = pcount[pslots[i]];
                        vs = i;
                     end
                  end
               end
               victim = pslots[vs];
               pcached[victim] = 0;
               r.removed = 1'b1;
               r.removed_id = ID_W'(victim);
               pslots[vs] = id;
               pslot_of[id] = vs;
               n_evict++;
            end
            pcached[id] = 1;
            r.admitted = 1'b1;
            n_admit++;
         end
         if (pcount[id] != 16'hFFFF) pcount[id]++;
      end else if (act == ACT_DECREMENT) begin
         if (pcount[id] != 0) begin
            pcount[id]--;
            if (pcount[id] < cfg_lower && pcached[id]) begin
               s = pslot_of[id];
               pcached[id] = 0;
               if (s < pused) begin
                  // close the gap left by the removed slot
                  for (int i = s; i + 1 < pused; i++) begin
                     pslots[i] = pslots[i+1];
                     pslot_of[pslots[i]] = i;
                  end
                  pused--;
               end
               r.removed = 1'b1;
               r.removed_id = id;
               n_remove++;
            end
         end
      end
      r.hit = pcached[id];
      r.count = pcount[id];
      r.occupancy = SLOTN_W'(pused);
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_transaction(logic [1:0] act, logic [ID_W-1:0] id, logic [7:0] rnd,
                                   bit typed, cache_rsp_t want);
      int gap;
      cache_rsp_t p;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_content_id <= id;
      req_random_slot <= rnd;
      do @(posedge clock); while (req_stall);
      p = predict_policy(act, id, rnd);
      pending_rsp = {pending_rsp, (typed ? want : p)};
      n_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_policy(policy_cfg_t c);
      logic [CSR_DATA_W-1:0] capw;
      capw = {7'($urandom_range(0, 127)), c.cap[8:0]};
      csr_write <= 1'b1;
      csr_index <= CSR_UPPER;
      csr_wdata <= CSR_DATA_W'(c.upper);
      @(posedge clock);
      csr_index <= CSR_LOWER;
      csr_wdata <= CSR_DATA_W'(c.lower);
      @(posedge clock);
      csr_index <= CSR_CAP;
      csr_wdata <= capw;
      @(posedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= CSR_DATA_W'(c.limit);
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= CSR_DATA_W'(c.mode);
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_upper = c.upper & 16'hFFFF;
      cfg_lower = c.lower & 16'hFFFF;
      cfg_cap = capw[8:0];
      cfg_limit = c.limit & 1;
      cfg_mode = c.mode & 1;
      calm = c.calm;
   endtask

   function automatic void add_row(logic [1:0] act, logic [ID_W-1:0] id, logic [7:0] rnd,
                                   bit typed, bit hit, int cnt, bit adm, bit rem,
                                   int rid, int occ);
      stim_row_t row;
      row.act = act;
      row.id = id;
      row.rnd = rnd;
      row.typed = typed;
      row.want = '{hit, CNT_OUT_W'(cnt), adm, rem, ID_W'(rid), SLOTN_W'(occ)};
      directed = {directed, row};
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      cache_rsp_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected transaction on rsp, expected none, got count %0d",
                     $time, rsp_count);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("hit", e.hit, rsp_hit);
            check_field("count", e.count, rsp_count);
            check_field("admitted", e.admitted, rsp_admitted);
            check_field("removed", e.removed, rsp_removed);
            check_field("removed_id", e.removed_id, rsp_removed_id);
            check_field("occupancy", e.occupancy, rsp_occupancy);
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm || r < 65) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 80);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned r, id;
      logic [1:0] act;
      policy_cfg_t sat;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = '0;
      req_content_id = '0;
      req_random_slot = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 0;
      n_items = 0;
      n_evict = 0;
      n_remove = 0;
      n_admit = 0;
      for (int i = 0; i < 256; i++) begin
         pcount[i] = '0;
         pcached[i] = 0;
      end
      pused = 0;
      cfg_upper = 3;
      cfg_lower = 1;
      cfg_cap = 16;
      cfg_limit = 1;
      cfg_mode = 1;

      // default policy after reset: admit at count 3, remove below 1
      add_row(ACT_LOOKUP, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_DECREMENT, 8'd255, 8'd0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_SPARE, 8'd255, 8'd255, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_INTEREST, 8'd255, 8'd255, 1, 0, 1, 0, 0, 0, 0);
      add_row(ACT_INTEREST, 8'd255, 8'd0, 1, 0, 2, 0, 0, 0, 0);
      add_row(ACT_INTEREST, 8'd255, 8'd0, 1, 0, 3, 0, 0, 0, 0);
      add_row(ACT_INTEREST, 8'd255, 8'd0, 1, 1, 4, 1, 0, 0, 1);
      add_row(ACT_LOOKUP, 8'd255, 8'd0, 1, 1, 4, 0, 0, 0, 1);
      add_row(ACT_DECREMENT, 8'd255, 8'd0, 1, 1, 3, 0, 0, 0, 1);
      add_row(ACT_DECREMENT, 8'd255, 8'd0, 1, 1, 2, 0, 0, 0, 1);
      add_row(ACT_DECREMENT, 8'd255, 8'd0, 1, 1, 1, 0, 0, 0, 1);
      add_row(ACT_DECREMENT, 8'd255, 8'd0, 1, 0, 0, 0, 1, 255, 0);
      for (int k = 0; k < 4; k++) add_row(ACT_INTEREST, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 4; k++) add_row(ACT_INTEREST, 8'd170, 8'd85, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_DECREMENT, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_LOOKUP, 8'd170, 8'd0, 0, 0, 0, 0, 0, 0, 0);

      phases[0] = '{3, 1, 16, 1, 1, 40, 0};
      phases[1] = '{2, 1, 4, 1, 0, 20, 1};
      phases[2] = '{0, 0, 1, 1, 1, 10, 0};
      phases[3] = '{65535, 65535, 0, 1, 0, 10, 0};
      phases[4] = '{0, 2, 256, 0, 1, 255, 1};
      phases[5] = '{1, 1, 511, 1, 0, 255, 0};
      phases[6] = '{4, 3, 2, 1, 1, 30, 0};
      phases[7] = '{2, 2, 8, 1, 0, 16, 0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_transaction(directed[i].act, directed[i].id, directed[i].rnd,
                          directed[i].typed, directed[i].want);
      wait_idle();

      // highest upper threshold: a short run of interests only counts up
      sat = '{65535, 0, 16, 1, 1, 0, 1};
      write_policy(sat);
      for (int k = 0; k < 8; k++)
         send_transaction(ACT_INTEREST, 8'd200, 8'd0, 0, '0);
      send_transaction(ACT_DECREMENT, 8'd200, 8'd0, 0, '0);
      send_transaction(ACT_LOOKUP, 8'd200, 8'd0, 0, '0);
      wait_idle();

      for (int p = 0; p < N_PHASE; p++) begin
         write_policy(phases[p]);
         for (int k = 0; k < PER_PHASE; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55) act = ACT_INTEREST;
            else if (r < 85) act = ACT_DECREMENT;
            else if (r < 95) act = ACT_LOOKUP;
            else act = ACT_SPARE;
            if ($urandom_range(0, 99) < 85) id = $urandom_range(0, phases[p].pool);
            else id = $urandom_range(0, 255);
            send_transaction(act, ID_W'(id), 8'($urandom_range(0, 255)), 0, '0);
         end
         wait_idle();
      end

      $display("covered %0d transactions, %0d results over %0d policy settings",
               n_items, n_results, N_PHASE + 2);
      $display("admissions %0d, evictions %0d, threshold removals %0d",
               n_admit, n_evict, n_remove);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
